// ===== rtl/h3d_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers of the 3d heat diffusion stencil
package h3d_pkg;

    // grid and data sizes
    localparam int MAX_DIM     = 64;
    localparam int SIZE_W      = 7;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DATA_W      = 32;
    localparam int COEF_W      = 16;
    localparam int FRAC_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int MIN_DIM     = 3;

    // window store geometry
    localparam int STORE_DEPTH = 2 * MAX_DIM * MAX_DIM + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MOD_SPLIT   = ADDR_W - 1;
    localparam int PLANE_W     = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int XY_W        = $clog2(MAX_DIM * MAX_DIM);
    localparam int LIN_W       = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);

    // neighbour reads, relative to the voxel under update
    localparam int N_RD        = 6;
    localparam int RD_CENTER   = 0;
    localparam int RD_XLO      = 1;
    localparam int RD_YLO      = 2;
    localparam int RD_YHI      = 3;
    localparam int RD_ZLO      = 4;
    localparam int RD_ZHI      = 5;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DT = 2'd3;

    // reset values of the configuration registers
    localparam logic [SIZE_W-1:0] SIZE_RST = 7'd16;
    localparam logic [COEF_W-1:0] COEF_RST = 16'd1638;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [COEF_W-1:0] coef_dt;
    } h3d_cfg_t;

    // what travels with a voxel up to the result word
    typedef struct packed {
        logic             frame_last;
        logic [IDX_W-1:0] pos_x;
        logic [IDX_W-1:0] pos_y;
        logic [IDX_W-1:0] pos_z;
    } h3d_tag_t;

    typedef struct packed {
        h3d_tag_t          tag;
        logic              emit;
        logic [DATA_W-1:0] temp;
    } h3d_meta_t;

    // one queue entry: the voxel plus its store addresses
    typedef struct packed {
        h3d_meta_t                     meta;
        logic [ADDR_W-1:0]             wr_addr;
        logic [N_RD-1:0][ADDR_W-1:0]   rd_addr;
    } h3d_item_t;

    // size register as the grid sees it: zero acts as one, clamp at max
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > SIZE_W'(MAX_DIM))
        begin
            r = SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

// ===== rtl/explicit_3d_heat_diffusion_stencil.sv =====
`timescale 1ns / 1ps
// top level of the streaming seven point 3d heat diffusion step
//
//   channel   direction  handshake             word
//   cfg       in         cfg_wr_en             cfg_index, cfg_data
//   in        in         in_valid / in_stall   temperature
//   out       out        out_valid / out_stall new_temperature, pos_x/y/z, frame_last
//
// one voxel word accepted per cycle while in_stall is low; every stage is registered
// result word of an interior voxel leaves after the word that completes its neighbourhood,
//   passing three front stages, the queue and six back stages
// rst_n clears counters, valid bits and queue; window store contents stay unknown
// out_stall holds the back pipeline, the four entry queue then fills, then in_stall rises
module explicit_3d_heat_diffusion_stencil import h3d_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] temperature,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] new_temperature,
    output logic [IDX_W-1:0]         pos_x,
    output logic [IDX_W-1:0]         pos_y,
    output logic [IDX_W-1:0]         pos_z,
    output logic                     frame_last
);

    h3d_cfg_t  cfg_reg;
    logic      q_push, q_full, q_pop, q_valid;
    h3d_item_t push_item, pop_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x  <= SIZE_RST;
            cfg_reg.size_y  <= SIZE_RST;
            cfg_reg.size_z  <= SIZE_RST;
            cfg_reg.coef_dt <= COEF_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SIZE_X:  cfg_reg.size_x  <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:  cfg_reg.size_y  <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:  cfg_reg.size_z  <= cfg_data[SIZE_W-1:0];
                REG_COEF_DT: cfg_reg.coef_dt <= cfg_data[COEF_W-1:0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // front end
    h3d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .temperature (temperature),
        .cfg         (cfg_reg),
        .q_push      (q_push),
        .q_item      (push_item),
        .q_full      (q_full)
    );

    // decoupling queue
    h3d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    // back end
    h3d_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef_dt         (cfg_reg.coef_dt),
        .q_valid         (q_valid),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .new_temperature (new_temperature),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .frame_last      (frame_last)
    );

endmodule

// ===== rtl/h3d_front.sv =====
`timescale 1ns / 1ps
// front end: voxel counters, interior test and window store addressing
module h3d_front import h3d_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] temperature,
    input  h3d_cfg_t                 cfg,
    output logic                     q_push,
    output h3d_item_t                q_item,
    input  logic                     q_full
);

    // modular subtract inside the store depth
    function automatic logic [ADDR_W-1:0] wrap_sub(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W-1:0] r;
        if (a >= b)
        begin
            r = a - b;
        end
        else
        begin
            r = a - b + ADDR_W'(STORE_DEPTH);
        end
        return r;
    endfunction

    logic [SIZE_W-1:0] sx, sy, sz;
    logic              move, accept;

    logic [IDX_W-1:0]  in_x_reg, in_y_reg, in_z_reg;
    logic [IDX_W-1:0]  in_x_next, in_y_next, in_z_next;

    logic [PLANE_W-1:0]           plane_reg;
    logic [N_RD-1:0][ADDR_W-1:0]  back_reg;

    logic              s1_v_reg, s2_v_reg, s3_v_reg;
    h3d_meta_t         s1_meta_reg, s2_meta_reg, s3_meta_reg;
    h3d_meta_t         s1_meta_next;
    logic [XY_W-1:0]   s1_xy_reg, s1_xy_next;
    logic [IDX_W-1:0]  s1_z_reg;
    logic [LIN_W-1:0]  s2_lin_reg, s2_lin_next;
    logic [ADDR_W-1:0] s3_addr_reg, s3_addr_next;

    assign sx = eff_size(cfg.size_x);
    assign sy = eff_size(cfg.size_y);
    assign sz = eff_size(cfg.size_z);

    // lock-step pipeline, held only by a full queue
    assign move     = !s3_v_reg || !q_full;
    assign accept   = in_valid && move;
    assign in_stall = !move;
    assign q_push   = s3_v_reg && !q_full;

    // counter advance, z innermost
    always_comb
    begin
        logic [SIZE_W-1:0] z_inc, y_inc, x_inc;
        z_inc     = SIZE_W'(in_z_reg) + SIZE_W'(1);
        y_inc     = SIZE_W'(in_y_reg) + SIZE_W'(1);
        x_inc     = SIZE_W'(in_x_reg) + SIZE_W'(1);
        in_x_next = in_x_reg;
        in_y_next = in_y_reg;
        in_z_next = z_inc[IDX_W-1:0];
        if (z_inc >= sz)
        begin
            in_z_next = '0;
            in_y_next = y_inc[IDX_W-1:0];
            if (y_inc >= sy)
            begin
                in_y_next = '0;
                in_x_next = x_inc[IDX_W-1:0];
                if (x_inc >= sx)
                begin
                    in_x_next = '0;
                end
            end
        end
    end

    // interior test of the voxel one plane back, and its position
    always_comb
    begin
        logic [SIZE_W-1:0] xe, ye, ze, cx;
        logic              sizes_ok, x_ok, y_ok, z_ok;
        xe = SIZE_W'(in_x_reg);
        ye = SIZE_W'(in_y_reg);
        ze = SIZE_W'(in_z_reg);
        cx = xe - SIZE_W'(1);
        sizes_ok = (sx >= SIZE_W'(MIN_DIM)) && (sy >= SIZE_W'(MIN_DIM)) &&
                   (sz >= SIZE_W'(MIN_DIM));
        x_ok = (xe >= SIZE_W'(2)) && (xe <= sx - SIZE_W'(1));
        y_ok = (ye >= SIZE_W'(1)) && (ye <= sy - SIZE_W'(2));
        z_ok = (ze >= SIZE_W'(1)) && (ze <= sz - SIZE_W'(2));
        s1_meta_next.emit           = sizes_ok && x_ok && y_ok && z_ok;
        s1_meta_next.temp           = temperature;
        s1_meta_next.tag.pos_x      = cx[IDX_W-1:0];
        s1_meta_next.tag.pos_y      = in_y_reg;
        s1_meta_next.tag.pos_z      = in_z_reg;
        s1_meta_next.tag.frame_last = (cx == sx - SIZE_W'(2)) && (ye == sy - SIZE_W'(2)) &&
                                      (ze == sz - SIZE_W'(2));
    end

    // linear index in two multiply steps, then reduced modulo the store depth
    assign s1_xy_next  = XY_W'(in_x_reg) * XY_W'(sy) + XY_W'(in_y_reg);
    assign s2_lin_next = LIN_W'(s1_xy_reg) * LIN_W'(sz) + LIN_W'(s1_z_reg);

    // depth is 2^split + 1, so the high part folds in with a minus sign
    always_comb
    begin
        logic [ADDR_W-1:0] lo, hi;
        lo = ADDR_W'(s2_lin_reg[MOD_SPLIT-1:0]);
        hi = ADDR_W'(s2_lin_reg[LIN_W-1:MOD_SPLIT]);
        s3_addr_next = wrap_sub(lo, hi);
    end

    // neighbour distances, settled from the sizes
    always_ff @(posedge clk)
    begin
        plane_reg           <= PLANE_W'(sy) * PLANE_W'(sz);
        back_reg[RD_CENTER] <= ADDR_W'(plane_reg);
        back_reg[RD_XLO]    <= ADDR_W'(plane_reg) << 1;
        back_reg[RD_YLO]    <= ADDR_W'(plane_reg) + ADDR_W'(sz);
        back_reg[RD_YHI]    <= ADDR_W'(plane_reg) - ADDR_W'(sz);
        back_reg[RD_ZLO]    <= ADDR_W'(plane_reg) + ADDR_W'(1);
        back_reg[RD_ZHI]    <= ADDR_W'(plane_reg) - ADDR_W'(1);
    end

    // queue word
    always_comb
    begin
        q_item.meta    = s3_meta_reg;
        q_item.wr_addr = s3_addr_reg;
        for (int i = 0; i < N_RD; i++)
        begin
            q_item.rd_addr[i] = wrap_sub(s3_addr_reg, back_reg[i]);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_x_reg <= '0;
            in_y_reg <= '0;
            in_z_reg <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_x_reg <= in_x_next;
                in_y_reg <= in_y_next;
                in_z_reg <= in_z_next;
            end
            if (move)
            begin
                s1_v_reg <= accept;
                s2_v_reg <= s1_v_reg;
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            s1_meta_reg <= s1_meta_next;
            s1_xy_reg   <= s1_xy_next;
            s1_z_reg    <= in_z_reg;
            s2_meta_reg <= s1_meta_reg;
            s2_lin_reg  <= s2_lin_next;
            s3_meta_reg <= s2_meta_reg;
            s3_addr_reg <= s3_addr_next;
        end
    end

endmodule

// ===== rtl/h3d_queue.sv =====
`timescale 1ns / 1ps
// short fifo between front end and back end
module h3d_queue import h3d_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  h3d_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output h3d_item_t pop_item
);

    h3d_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    // fill count checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + QCNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

// ===== rtl/h3d_back.sv =====
`timescale 1ns / 1ps
// back end: window store, seven point update, rounding and saturation
module h3d_back import h3d_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [COEF_W-1:0]        coef_dt,
    input  logic                     q_valid,
    input  h3d_item_t                q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] new_temperature,
    output logic [IDX_W-1:0]         pos_x,
    output logic [IDX_W-1:0]         pos_y,
    output logic [IDX_W-1:0]         pos_z,
    output logic                     frame_last
);

    localparam int SUM3_W   = DATA_W + 2;
    localparam int C6_W     = DATA_W + 3;
    localparam int LAP_W    = DATA_W + 4;
    localparam int LAP_LO_W = 18;
    localparam int LAP_HI_W = LAP_W - LAP_LO_W;
    localparam int PH_W     = LAP_HI_W + COEF_W + 1;
    localparam int PL_W     = LAP_LO_W + COEF_W;
    localparam int P_W      = LAP_W + COEF_W + 1;
    localparam int D_W      = P_W - FRAC_W;
    localparam int R_W      = D_W + 1;
    localparam logic signed [P_W-1:0] ROUND_P = P_W'(1) <<< (FRAC_W - 1);

    logic move;

    // three copies of the store, two read ports each
    logic [DATA_W-1:0] mem_a [STORE_DEPTH];
    logic [DATA_W-1:0] mem_b [STORE_DEPTH];
    logic [DATA_W-1:0] mem_c [STORE_DEPTH];

    logic                        b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg, b5_v_reg, b6_v_reg;
    h3d_tag_t                    b1_tag_reg, b2_tag_reg, b3_tag_reg, b4_tag_reg, b5_tag_reg;
    h3d_tag_t                    b6_tag_reg;
    logic [DATA_W-1:0]           b1_t_reg;
    logic [N_RD-1:0][DATA_W-1:0] b1_rd_reg;
    logic signed [DATA_W-1:0]    b2_c_reg, b3_c_reg, b4_c_reg, b5_c_reg;
    logic signed [SUM3_W-1:0]    b2_sa_reg, b2_sb_reg, sa_next, sb_next;
    logic signed [C6_W-1:0]      b2_c6_reg, c6_next;
    logic signed [LAP_W-1:0]     b3_lap_reg, lap_next;
    logic signed [PH_W-1:0]      b4_ph_reg, ph_next;
    logic [PL_W-1:0]             b4_pl_reg, pl_next;
    logic signed [P_W-1:0]       p_sum;
    logic signed [D_W-1:0]       b5_d_reg;
    logic signed [R_W-1:0]       r_sum;
    logic signed [DATA_W-1:0]    r_sat, b6_r_reg;

    // pipeline held only by a stalled result word
    assign move      = !(b6_v_reg && out_stall);
    assign q_pop     = q_valid && move;
    assign out_valid = b6_v_reg;

    // store write and neighbour reads of one voxel
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mem_a[q_item.wr_addr]  <= q_item.meta.temp;
            mem_b[q_item.wr_addr]  <= q_item.meta.temp;
            mem_c[q_item.wr_addr]  <= q_item.meta.temp;
            b1_rd_reg[RD_CENTER]   <= mem_a[q_item.rd_addr[RD_CENTER]];
            b1_rd_reg[RD_XLO]      <= mem_a[q_item.rd_addr[RD_XLO]];
            b1_rd_reg[RD_YLO]      <= mem_b[q_item.rd_addr[RD_YLO]];
            b1_rd_reg[RD_YHI]      <= mem_b[q_item.rd_addr[RD_YHI]];
            b1_rd_reg[RD_ZLO]      <= mem_c[q_item.rd_addr[RD_ZLO]];
            b1_rd_reg[RD_ZHI]      <= mem_c[q_item.rd_addr[RD_ZHI]];
            b1_t_reg               <= q_item.meta.temp;
            b1_tag_reg             <= q_item.meta.tag;
        end
    end

    // partial neighbour sums and six times the center
    assign sa_next = SUM3_W'($signed(b1_t_reg)) + SUM3_W'($signed(b1_rd_reg[RD_XLO])) +
                     SUM3_W'($signed(b1_rd_reg[RD_YLO]));
    assign sb_next = SUM3_W'($signed(b1_rd_reg[RD_YHI])) +
                     SUM3_W'($signed(b1_rd_reg[RD_ZLO])) +
                     SUM3_W'($signed(b1_rd_reg[RD_ZHI]));
    assign c6_next = (C6_W'($signed(b1_rd_reg[RD_CENTER])) <<< 2) +
                     (C6_W'($signed(b1_rd_reg[RD_CENTER])) <<< 1);

    // laplacian
    assign lap_next = LAP_W'(b2_sa_reg) + LAP_W'(b2_sb_reg) - LAP_W'(b2_c6_reg);

    // laplacian times k as two partial products
    assign ph_next = PH_W'($signed(b3_lap_reg[LAP_W-1:LAP_LO_W])) *
                     PH_W'($signed({1'b0, coef_dt}));
    assign pl_next = PL_W'(b3_lap_reg[LAP_LO_W-1:0]) * PL_W'(coef_dt);

    // recombine, round half up, floor shift
    assign p_sum = (P_W'(b4_ph_reg) <<< LAP_LO_W) + P_W'($signed({1'b0, b4_pl_reg})) +
                   ROUND_P;

    // add to center and saturate
    assign r_sum = R_W'(b5_c_reg) + R_W'(b5_d_reg);
    always_comb
    begin
        logic [R_W-DATA_W:0] hi;
        hi = r_sum[R_W-1:DATA_W-1];
        if ((&hi) || !(|hi))
        begin
            r_sat = r_sum[DATA_W-1:0];
        end
        else if (r_sum[R_W-1])
        begin
            r_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // arithmetic stage payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            b2_sa_reg  <= sa_next;
            b2_sb_reg  <= sb_next;
            b2_c6_reg  <= c6_next;
            b2_c_reg   <= $signed(b1_rd_reg[RD_CENTER]);
            b2_tag_reg <= b1_tag_reg;
            b3_lap_reg <= lap_next;
            b3_c_reg   <= b2_c_reg;
            b3_tag_reg <= b2_tag_reg;
            b4_ph_reg  <= ph_next;
            b4_pl_reg  <= pl_next;
            b4_c_reg   <= b3_c_reg;
            b4_tag_reg <= b3_tag_reg;
            b5_d_reg   <= p_sum[P_W-1:FRAC_W];
            b5_c_reg   <= b4_c_reg;
            b5_tag_reg <= b4_tag_reg;
            b6_r_reg   <= r_sat;
            b6_tag_reg <= b5_tag_reg;
        end
    end

    // valid bits; only interior voxels go past the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            b5_v_reg <= 1'b0;
            b6_v_reg <= 1'b0;
        end
        else if (move)
        begin
            b1_v_reg <= q_pop && q_item.meta.emit;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
            b5_v_reg <= b4_v_reg;
            b6_v_reg <= b5_v_reg;
        end
    end

    // result word
    assign new_temperature = b6_r_reg;
    assign pos_x           = b6_tag_reg.pos_x;
    assign pos_y           = b6_tag_reg.pos_y;
    assign pos_z           = b6_tag_reg.pos_z;
    assign frame_last      = b6_tag_reg.frame_last;

endmodule
